/* sv/chip8_instruction_executor_macros.svh */
// Assertion macros used by the executor RTL.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define C8_ASSERT_IMP(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define C8_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/c8ie_pkg.sv */
`default_nettype none
package c8ie_pkg;
  localparam int unsigned MemDepth = 4096;
  localparam int unsigned RegCount = 16;
  localparam int unsigned AddrW = 12;
  localparam logic [3:0] FlagIdx = 4'hF;
  localparam logic [7:0] RegisterMaxValue = 8'd255;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRead = 2'd1;
  localparam logic [1:0] ActExec = 2'd2;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StUnimpl = 2'd2;

  localparam logic [11:0] OpCls = 12'h0E0;
  localparam logic [11:0] OpRet = 12'h0EE;
  localparam logic [7:0] FxLdVxDt = 8'h07;
  localparam logic [7:0] FxWaitKey = 8'h0A;
  localparam logic [7:0] FxLdDt = 8'h15;
  localparam logic [7:0] FxLdSt = 8'h18;
  localparam logic [7:0] FxAddI = 8'h1E;
  localparam logic [7:0] FxBcd = 8'h33;
  localparam logic [7:0] FxStore = 8'h55;
  localparam logic [7:0] FxLoad = 8'h65;
  localparam logic [7:0] ExSkp = 8'h9E;
  localparam logic [7:0] ExSknp = 8'hA1;
  localparam logic [7:0] MsbMask = 8'h80;
  localparam logic [7:0] LsbMask = 8'h01;

  // Memory port request.
  typedef struct packed {
    logic        en;
    logic        we;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;
endpackage
`default_nettype wire

/* sv/chip8_instruction_executor.sv */
// Channel | Direction | Beat contents
// in      | input     | action_i, address_i, data_i, random_byte_i
// out     | output    | read_data_o, next_pc_o, index_value_o, delay_timer_o,
//         |           | sound_timer_o, status_o
// cfg     | input     | APB writes of program_start (0x0), stack_start (0x4)
// An accepted memory write goes straight to the output stage; a read, the two
// instruction bytes of a fetch and each byte that a call, return, BCD, Fx55
// or Fx65 moves take turns on the single memory port before the result beat.
// Reset clears the registers and loads pc with 0 and sp with 200; memory is
// not reset. A result beat waits in the output register until taken; the core
// stalls before loading it only while it is still full.
`default_nettype none
`include "chip8_instruction_executor_macros.svh"
module chip8_instruction_executor #(
  parameter int unsigned MEM_DEPTH = c8ie_pkg::MemDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [7:0]  random_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_data_o,
  output logic [11:0]      next_pc_o,
  output logic [11:0]      index_value_o,
  output logic [7:0]       delay_timer_o,
  output logic [7:0]       sound_timer_o,
  output logic [1:0]       status_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MEM   = 8'b0000_0010,
    S_FHI   = 8'b0000_0100,
    S_FLO   = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_RD2   = 8'b0010_0000,
    S_MULTI = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  c8ie_pkg::mem_req_t req;
  logic [7:0] rdata;

  logic [7:0]  v_q [c8ie_pkg::RegCount];
  logic [7:0]  v_d [c8ie_pkg::RegCount];
  logic [11:0] i_q, i_d, pc_q, pc_d, pstart_q, pstart_d;
  logic [7:0]  sp_q, sp_d, sstart_q, sstart_d, dt_q, dt_d, st_q, st_d;
  logic [7:0]  rnd_q, rnd_d, hi_q, hi_d, lo_q, lo_d, tmp_q, tmp_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  rd_q, rd_d;
  logic [1:0]  stat_q, stat_d;
  logic        ovalid_q, ovalid_d;
  logic        out_load;
  logic [7:0]  ord_q, odt_q, ost_q;
  logic [11:0] opc_q, oidx_q;
  logic [1:0]  ostat_q;

  c8ie_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
    .clk_i(clk_i), .req_i(req), .rdata_o(rdata)
  );

  // APB port, always ready.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = {20'd0, pstart_q};
      default: prdata = {24'd0, sstart_q};
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign read_data_o = ord_q;
  assign next_pc_o = opc_q;
  assign index_value_o = oidx_q;
  assign delay_timer_o = odt_q;
  assign sound_timer_o = ost_q;
  assign status_o = ostat_q;

  // Decoded instruction fields.
  logic [3:0]  x, y, n;
  logic [11:0] nnn;
  logic [7:0]  vx, vy;
  logic [8:0]  sum9;
  logic [7:0]  tens_q, tens_d;
  assign x = hi_q[3:0];
  assign y = lo_q[7:4];
  assign n = lo_q[3:0];
  assign nnn = {hi_q[3:0], lo_q};
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign sum9 = {1'b0, vx} + {1'b0, vy};

  // Sequencer: APB writes, memory actions, fetch, decode, execute, multi-byte memory work and output hand-off.
  always_comb begin
    state_d = state_q;
    req = '0;
    v_d = v_q;
    i_d = i_q; pc_d = pc_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
    pstart_d = pstart_q; sstart_d = sstart_q;
    rnd_d = rnd_q; hi_d = hi_q; lo_d = lo_q; tmp_d = tmp_q;
    cnt_d = cnt_q; rd_d = rd_q; stat_d = stat_q; ovalid_d = ovalid_q;
    tens_d = tens_q;
    out_load = 1'b0;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          case (paddr[2])
            1'b0: begin
              pstart_d = pwdata[11:0];
              pc_d = pwdata[11:0];
            end
            default: begin
              sstart_d = pwdata[7:0];
              sp_d = pwdata[7:0];
            end
          endcase
        end
        if (in_valid_i && in_ready_o) begin
          rnd_d = random_byte_i;
          rd_d = '0;
          stat_d = c8ie_pkg::StDone;
          case (action_i)
            c8ie_pkg::ActWrite: begin
              req = '{en: 1'b1, we: 1'b1, addr: address_i, wdata: data_i};
              state_d = S_OUT;
            end
            c8ie_pkg::ActRead: begin
              req = '{en: 1'b1, we: 1'b0, addr: address_i, wdata: 8'd0};
              state_d = S_MEM;
            end
            c8ie_pkg::ActExec: begin
              req = '{en: 1'b1, we: 1'b0, addr: pc_q, wdata: 8'd0};
              state_d = S_FHI;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_MEM: begin
        rd_d = rdata;
        state_d = S_OUT;
      end
      S_FHI: begin
        hi_d = rdata;
        req = '{en: 1'b1, we: 1'b0, addr: pc_q + 12'd1, wdata: 8'd0};
        state_d = S_FLO;
      end
      S_FLO: begin
        lo_d = rdata;
        pc_d = pc_q + 12'd2;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
        case (hi_q[7:4])
          4'h0: begin
            if (nnn == c8ie_pkg::OpCls) begin
              stat_d = c8ie_pkg::StUnimpl;
            end else if (nnn == c8ie_pkg::OpRet) begin
              req = '{en: 1'b1, we: 1'b0, addr: {4'd0, sp_q - 8'd2}, wdata: 8'd0};
              cnt_d = 5'd0;
              state_d = S_RD2;
            end
          end
          4'h1: pc_d = nnn;
          4'h2: begin
            req = '{en: 1'b1, we: 1'b1, addr: {4'd0, sp_q}, wdata: {4'd0, pc_q[11:8]}};
            cnt_d = 5'd0;
            state_d = S_MULTI;
          end
          4'h3: if (vx == lo_q) pc_d = pc_q + 12'd2;
          4'h4: if (vx != lo_q) pc_d = pc_q + 12'd2;
          4'h5: if (vx == vy) pc_d = pc_q + 12'd2;
          4'h6: v_d[x] = lo_q;
          4'h7: v_d[x] = vx + lo_q;
          4'h8: begin
            case (n)
              4'h0: v_d[x] = vy;
              4'h1: v_d[x] = vx | vy;
              4'h2: v_d[x] = vx & vy;
              4'h3: v_d[x] = vx ^ vy;
              4'h4: begin
                v_d[c8ie_pkg::FlagIdx] = {7'd0, sum9 > {1'b0, c8ie_pkg::RegisterMaxValue}};
                v_d[x] = sum9[7:0];
              end
              4'h5: begin
                v_d[c8ie_pkg::FlagIdx] = {7'd0, vx > vy};
                v_d[x] = vx - vy;
              end
              4'h6: begin
                v_d[c8ie_pkg::FlagIdx] = vx & c8ie_pkg::LsbMask;
                v_d[x] = vx >> 1;
              end
              4'h7: begin
                v_d[c8ie_pkg::FlagIdx] = {7'd0, vy > vx};
                v_d[x] = vy - vx;
              end
              4'hE: begin
                v_d[c8ie_pkg::FlagIdx] = {7'd0, |(vx & c8ie_pkg::MsbMask)};
                v_d[x] = vx << 1;
              end
              default: stat_d = c8ie_pkg::StInvalid;
            endcase
          end
          4'h9: if (vx != vy) pc_d = pc_q + 12'd2;
          4'hA: i_d = nnn;
          4'hB: pc_d = nnn + {4'd0, v_q[0]};
          4'hC: v_d[x] = rnd_q & lo_q;
          4'hD: stat_d = c8ie_pkg::StUnimpl;
          4'hE: begin
            if (lo_q == c8ie_pkg::ExSkp || lo_q == c8ie_pkg::ExSknp) begin
              stat_d = c8ie_pkg::StUnimpl;
            end else begin
              stat_d = c8ie_pkg::StInvalid;
            end
          end
          default: begin
            case (lo_q)
              c8ie_pkg::FxLdVxDt: v_d[x] = dt_q;
              c8ie_pkg::FxWaitKey: stat_d = c8ie_pkg::StUnimpl;
              c8ie_pkg::FxLdDt: dt_d = vx;
              c8ie_pkg::FxLdSt: st_d = vx;
              c8ie_pkg::FxAddI: i_d = i_q + {4'd0, vx};
              c8ie_pkg::FxBcd: begin
                // Hundreds now; tens and units follow.
                req = '{en: 1'b1, we: 1'b1, addr: i_q,
                        wdata: (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0};
                tmp_d = (vx >= 8'd200) ? vx - 8'd200 : (vx >= 8'd100) ? vx - 8'd100 : vx;
                cnt_d = 5'd1;
                state_d = S_MULTI;
              end
              c8ie_pkg::FxStore: begin
                req = '{en: 1'b1, we: 1'b1, addr: i_q, wdata: v_q[0]};
                cnt_d = 5'd1;
                state_d = (x == 4'd0) ? S_OUT : S_MULTI;
              end
              c8ie_pkg::FxLoad: begin
                req = '{en: 1'b1, we: 1'b0, addr: i_q, wdata: 8'd0};
                cnt_d = 5'd0;
                state_d = S_MULTI;
              end
              default: ;
            endcase
          end
        endcase
      end
      S_RD2: begin
        // Return: high byte arrives, fetch low byte, then assemble.
        if (cnt_q == 5'd0) begin
          tmp_d = rdata;
          req = '{en: 1'b1, we: 1'b0, addr: {4'd0, sp_q - 8'd1}, wdata: 8'd0};
          cnt_d = 5'd1;
        end else begin
          pc_d = {tmp_q[3:0], rdata};
          sp_d = sp_q - 8'd2;
          state_d = S_OUT;
        end
      end
      S_MULTI: begin
        case (hi_q[7:4])
          4'h2: begin
            req = '{en: 1'b1, we: 1'b1, addr: {4'd0, sp_q + 8'd1}, wdata: pc_q[7:0]};
            sp_d = sp_q + 8'd2;
            pc_d = nnn;
            state_d = S_OUT;
          end
          default: begin
            case (lo_q)
              c8ie_pkg::FxBcd: begin
                if (cnt_q == 5'd1) begin
                  tens_d = (tmp_q >= 8'd90) ? 8'd9 : (tmp_q >= 8'd80) ? 8'd8 :
                           (tmp_q >= 8'd70) ? 8'd7 : (tmp_q >= 8'd60) ? 8'd6 :
                           (tmp_q >= 8'd50) ? 8'd5 : (tmp_q >= 8'd40) ? 8'd4 :
                           (tmp_q >= 8'd30) ? 8'd3 : (tmp_q >= 8'd20) ? 8'd2 :
                           (tmp_q >= 8'd10) ? 8'd1 : 8'd0;
                  cnt_d = 5'd2;
                end else if (cnt_q == 5'd2) begin
                  req = '{en: 1'b1, we: 1'b1, addr: i_q + 12'd1, wdata: tens_q};
                  tmp_d = tmp_q - 8'((tens_q << 3) + (tens_q << 1));
                  cnt_d = 5'd3;
                end else begin
                  req = '{en: 1'b1, we: 1'b1, addr: i_q + 12'd2, wdata: tmp_q};
                  state_d = S_OUT;
                end
              end
              c8ie_pkg::FxStore: begin
                req = '{en: 1'b1, we: 1'b1, addr: i_q + {7'd0, cnt_q},
                        wdata: v_q[cnt_q[3:0]]};
                cnt_d = cnt_q + 5'd1;
                if (cnt_q[3:0] == x) state_d = S_OUT;
              end
              default: begin
                // Fx65: request byte cnt, then store the arriving byte (index cnt-1 while cnt[4] is set).
                if (cnt_q[4]) begin
                  v_d[cnt_q[3:0] - 4'd1] = rdata;
                  cnt_d = {1'b0, cnt_q[3:0]};
                  if (cnt_q[3:0] - 4'd1 == x) state_d = S_OUT;
                end else begin
                  req = '{en: 1'b1, we: 1'b0, addr: i_q + {7'd0, cnt_q}, wdata: 8'd0};
                  cnt_d = {1'b1, cnt_q[3:0] + 4'd1};
                end
              end
            endcase
          end
        endcase
      end
      S_OUT: begin
        // Load the output register once it is free or being emptied.
        if (!ovalid_q || out_ready_i) begin
          out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      i_q <= '0; pc_q <= '0; pstart_q <= '0;
      sp_q <= 8'd200; sstart_q <= 8'd200; dt_q <= '0; st_q <= '0;
      for (int k = 0; k < c8ie_pkg::RegCount; k++) v_q[k] <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      i_q <= i_d; pc_q <= pc_d; pstart_q <= pstart_d;
      sp_q <= sp_d; sstart_q <= sstart_d; dt_q <= dt_d; st_q <= st_d;
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d; hi_q <= hi_d; lo_q <= lo_d;
    tmp_q <= tmp_d; cnt_q <= cnt_d; rd_q <= rd_d; stat_q <= stat_d;
    tens_q <= tens_d;
  end

  // Output register, separate from the architectural state.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ord_q <= rd_q;
      opc_q <= pc_q;
      oidx_q <= i_q;
      odt_q <= dt_q;
      ost_q <= st_q;
      ostat_q <= stat_q;
    end
  end

  `C8_ASSERT_IMP(a_rdy_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE)
  `C8_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
                  !in_ready_o)
  `C8_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule
`default_nettype wire

/* sv/c8ie_mem.sv */
`default_nettype none
module c8ie_mem #(
  parameter int unsigned MEM_DEPTH = c8ie_pkg::MemDepth
) (
  input  wire logic             clk_i,
  input  c8ie_pkg::mem_req_t    req_i,
  output logic [7:0]            rdata_o
);
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [15:0] Depth1 = 16'(MEM_DEPTH);
  localparam logic [15:0] Depth2 = 16'(2 * MEM_DEPTH);
  localparam logic [15:0] Depth4 = 16'(4 * MEM_DEPTH);

  logic [7:0] mem [MEM_DEPTH];
  logic [AW-1:0] idx;
  logic [15:0] rem;

  // Map the 12-bit address onto the configured depth. The user must keep the
  // depth at least 512; the block does not check it. The quotient then stays
  // below eight and three compare-and-subtract steps give the remainder.
  always_comb begin
    rem = {4'd0, req_i.addr};
    if (rem >= Depth4) rem = rem - Depth4;
    if (rem >= Depth2) rem = rem - Depth2;
    if (rem >= Depth1) rem = rem - Depth1;
    idx = rem[AW-1:0];
  end

  // Single-port synchronous RAM; read data is registered and appears in the cycle after the request.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[idx] <= req_i.wdata;
      end
      rdata_o <= mem[idx];
    end
  end
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  localparam logic [1:0] ActNone = 2'd3;
  localparam logic [2:0] RegProgStart = 3'd0;
  localparam logic [2:0] RegStackStart = 3'd4;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 60;
  localparam logic [7:0] FxCodes [9] = '{c8ie_pkg::FxLdVxDt, c8ie_pkg::FxWaitKey,
                                         c8ie_pkg::FxLdDt, c8ie_pkg::FxLdSt,
                                         c8ie_pkg::FxAddI, c8ie_pkg::FxBcd,
                                         c8ie_pkg::FxStore, c8ie_pkg::FxLoad, 8'h99};
  localparam logic [3:0] AluCodes [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6,
                                          4'h7, 4'hE};

  typedef struct packed {
    logic [7:0]  rd;
    logic [11:0] pc;
    logic [11:0] idx;
    logic [7:0]  dt;
    logic [7:0]  st;
    logic [1:0]  status;
  } cpu_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [11:0] address_i;
  logic [7:0]  data_i;
  logic [7:0]  random_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  read_data_o;
  logic [11:0] next_pc_o;
  logic [11:0] index_value_o;
  logic [7:0]  delay_timer_o;
  logic [7:0]  sound_timer_o;
  logic [1:0]  status_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // CPU state as the testbench predicts it.
  logic [7:0]  mem_img [4096];
  bit          mem_known [4096];
  logic [7:0]  vregs [16];
  logic [11:0] cpu_idx;
  logic [11:0] cpu_pc;
  logic [11:0] prog_start;
  logic [7:0]  cpu_sp;
  logic [7:0]  stack_base;
  logic [7:0]  cpu_dt;
  logic [7:0]  cpu_st;

  cpu_result_t pending_results[$];
  int          fail_count;
  int          cycle_count;
  bit          idle_on;
  int          hold_left;
  int          stall_left;

  chip8_instruction_executor u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .action_i(action_i), .address_i(address_i), .data_i(data_i),
    .random_byte_i(random_byte_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .read_data_o(read_data_o), .next_pc_o(next_pc_o), .index_value_o(index_value_o),
    .delay_timer_o(delay_timer_o), .sound_timer_o(sound_timer_o), .status_o(status_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void mem_store(input logic [11:0] a, input logic [7:0] v);
    mem_img[a] = v;
    mem_known[a] = 1'b1;
  endfunction

  // Executes the instruction at pc and returns its status.
  function automatic logic [1:0] exec_instr(input logic [7:0] rnd);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [3:0]  x;
    logic [11:0] nnn;
    logic [8:0]  sum;
    hi = mem_img[cpu_pc];
    lo = mem_img[cpu_pc + 12'd1];
    nnn = {hi[3:0], lo};
    x = hi[3:0];
    vx = vregs[x];
    vy = vregs[lo[7:4]];
    cpu_pc = cpu_pc + 12'd2;
    case (hi[7:4])
      4'h0: begin
        if (nnn == c8ie_pkg::OpCls) return c8ie_pkg::StUnimpl;
        if (nnn == c8ie_pkg::OpRet) begin
          cpu_pc = {mem_img[{4'd0, cpu_sp - 8'd2}][3:0], mem_img[{4'd0, cpu_sp - 8'd1}]};
          cpu_sp = cpu_sp - 8'd2;
        end
      end
      4'h1: cpu_pc = nnn;
      4'h2: begin
        mem_store({4'd0, cpu_sp}, {4'd0, cpu_pc[11:8]});
        mem_store({4'd0, cpu_sp + 8'd1}, cpu_pc[7:0]);
        cpu_sp = cpu_sp + 8'd2;
        cpu_pc = nnn;
      end
      4'h3: if (vx == lo) cpu_pc = cpu_pc + 12'd2;
      4'h4: if (vx != lo) cpu_pc = cpu_pc + 12'd2;
      4'h5: if (vx == vy) cpu_pc = cpu_pc + 12'd2;
      4'h6: vregs[x] = lo;
      4'h7: vregs[x] = vx + lo;
      4'h8: begin
        case (lo[3:0])
          4'h0: vregs[x] = vy;
          4'h1: vregs[x] = vx | vy;
          4'h2: vregs[x] = vx & vy;
          4'h3: vregs[x] = vx ^ vy;
          4'h4: begin
            sum = {1'b0, vx} + {1'b0, vy};
            vregs[c8ie_pkg::FlagIdx] = {7'd0, sum[8]};
            vregs[x] = sum[7:0];
          end
          4'h5: begin
            vregs[c8ie_pkg::FlagIdx] = {7'd0, vx > vy};
            vregs[x] = vx - vy;
          end
          4'h6: begin
            vregs[c8ie_pkg::FlagIdx] = vx & c8ie_pkg::LsbMask;
            vregs[x] = vx >> 1;
          end
          4'h7: begin
            vregs[c8ie_pkg::FlagIdx] = {7'd0, vy > vx};
            vregs[x] = vy - vx;
          end
          4'hE: begin
            vregs[c8ie_pkg::FlagIdx] = (vx & c8ie_pkg::MsbMask) >> 7;
            vregs[x] = vx << 1;
          end
          default: return c8ie_pkg::StInvalid;
        endcase
      end
      4'h9: if (vx != vy) cpu_pc = cpu_pc + 12'd2;
      4'hA: cpu_idx = nnn;
      4'hB: cpu_pc = nnn + {4'd0, vregs[0]};
      4'hC: vregs[x] = rnd & lo;
      4'hD: return c8ie_pkg::StUnimpl;
      4'hE: return (lo == c8ie_pkg::ExSkp || lo == c8ie_pkg::ExSknp) ?
                   c8ie_pkg::StUnimpl : c8ie_pkg::StInvalid;
      default: begin
        case (lo)
          c8ie_pkg::FxLdVxDt: vregs[x] = cpu_dt;
          c8ie_pkg::FxWaitKey: return c8ie_pkg::StUnimpl;
          c8ie_pkg::FxLdDt: cpu_dt = vx;
          c8ie_pkg::FxLdSt: cpu_st = vx;
          c8ie_pkg::FxAddI: cpu_idx = cpu_idx + {4'd0, vx};
          c8ie_pkg::FxBcd: begin
            mem_store(cpu_idx, vx / 8'd100);
            mem_store(cpu_idx + 12'd1, (vx / 8'd10) % 8'd10);
            mem_store(cpu_idx + 12'd2, vx % 8'd10);
          end
          c8ie_pkg::FxStore:
            for (int i = 0; i <= x; i++) mem_store(cpu_idx + i[11:0], vregs[i]);
          c8ie_pkg::FxLoad:
            for (int i = 0; i <= x; i++) vregs[i] = mem_img[cpu_idx + i[11:0]];
          default: ;
        endcase
      end
    endcase
    return c8ie_pkg::StDone;
  endfunction

  // Updates the predicted state for one accepted beat and queues its result.
  function automatic void predict_result(input logic [1:0] act, input logic [11:0] addr,
                                         input logic [7:0] data, input logic [7:0] rnd);
    cpu_result_t r;
    r = '0;
    case (act)
      c8ie_pkg::ActWrite: mem_store(addr, data);
      c8ie_pkg::ActRead: r.rd = mem_img[addr];
      c8ie_pkg::ActExec: r.status = exec_instr(rnd);
      default: ;
    endcase
    r.pc = cpu_pc;
    r.idx = cpu_idx;
    r.dt = cpu_dt;
    r.st = cpu_st;
    pending_results.push_back(r);
  endfunction

  // Sends one input beat, starting at a falling edge, and now and then drops valid for a random gap.
  task automatic send_beat(input logic [1:0] act, input logic [11:0] addr,
                           input logic [7:0] data, input logic [7:0] rnd);
    int gap;
    in_valid_i <= 1'b1;
    action_i <= act;
    address_i <= addr;
    data_i <= data;
    random_byte_i <= rnd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_result(act, addr, data, rnd);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Makes sure a byte has been written before anything reads it.
  task automatic cover_byte(input logic [11:0] a);
    if (!mem_known[a]) send_beat(c8ie_pkg::ActWrite, a, 8'($urandom), 8'($urandom));
  endtask

  // Places an instruction at pc, with any data it reads, then executes it.
  task automatic run_op(input logic [15:0] op, input logic [7:0] rnd);
    logic [11:0] at;
    if (op == {4'h0, c8ie_pkg::OpRet}) begin
      cover_byte({4'd0, cpu_sp - 8'd2});
      cover_byte({4'd0, cpu_sp - 8'd1});
    end
    if (op[15:12] == 4'hF && op[7:0] == c8ie_pkg::FxLoad)
      for (int i = 0; i <= op[11:8]; i++) cover_byte(cpu_idx + i[11:0]);
    at = cpu_pc;
    send_beat(c8ie_pkg::ActWrite, at, op[15:8], 8'($urandom));
    send_beat(c8ie_pkg::ActWrite, at + 12'd1, op[7:0], 8'($urandom));
    send_beat(c8ie_pkg::ActExec, 12'($urandom), 8'($urandom), rnd);
  endtask

  // Lowers valid and lets the core go idle.
  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write with setup and access cycles; the core must be idle.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegProgStart) begin
      prog_start = value[11:0];
      cpu_pc = prog_start;
    end else begin
      stack_base = value[7:0];
      cpu_sp = stack_base;
    end
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] op;
    op = 16'($urandom);
    case (op[15:12])
      4'h0: begin
        case ($urandom_range(0, 2))
          0: op = {4'h0, c8ie_pkg::OpCls};
          1: op = {4'h0, c8ie_pkg::OpRet};
          default: ;
        endcase
      end
      4'h8: if ($urandom_range(0, 7) != 0) op[3:0] = AluCodes[$urandom_range(0, 8)];
      4'hE: begin
        case ($urandom_range(0, 2))
          0: op[7:0] = c8ie_pkg::ExSkp;
          1: op[7:0] = c8ie_pkg::ExSknp;
          default: ;
        endcase
      end
      4'hF: if ($urandom_range(0, 7) != 0) op[7:0] = FxCodes[$urandom_range(0, 8)];
      default: ;
    endcase
    return op;
  endfunction

  task automatic random_item();
    logic [11:0] a;
    case ($urandom_range(0, 19))
      0, 1: send_beat(c8ie_pkg::ActWrite, 12'($urandom), 8'($urandom), 8'($urandom));
      2, 3: begin
        a = 12'($urandom);
        cover_byte(a);
        send_beat(c8ie_pkg::ActRead, a, 8'($urandom), 8'($urandom));
      end
      4: send_beat(ActNone, 12'($urandom), 8'($urandom), 8'($urandom));
      default: run_op(random_op(), 8'($urandom));
    endcase
  endtask

  // Receiver with random stalls and an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!idle_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk_i) begin
    cpu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result beat, pc %h", next_pc_o);
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.rd || next_pc_o !== want.pc || index_value_o !== want.idx
            || delay_timer_o !== want.dt || sound_timer_o !== want.st
            || status_o !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: exp rd %h pc %h i %h dt %h st %h s %0d, got %h %h %h %h %h %0d",
                     want.rd, want.pc, want.idx, want.dt, want.st, want.status,
                     read_data_o, next_pc_o, index_value_o, delay_timer_o, sound_timer_o,
                     status_o);
        end
      end
    end
  end

  task automatic test_memory_extremes();
    send_beat(c8ie_pkg::ActWrite, 12'h000, 8'h00, 8'hFF);
    send_beat(c8ie_pkg::ActWrite, 12'hFFF, 8'hFF, 8'h00);
    send_beat(c8ie_pkg::ActRead, 12'h000, 8'hFF, 8'h00);
    send_beat(c8ie_pkg::ActRead, 12'hFFF, 8'h00, 8'hFF);
    send_beat(ActNone, 12'hFFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_opcodes();
    // Carry, borrow with equal operands, shifts and the flag as a target.
    run_op(16'h60FF, 8'h00);
    run_op(16'h6F01, 8'h00);
    run_op(16'h80F4, 8'h00);
    run_op(16'h8F05, 8'h00);
    run_op(16'h8F0E, 8'h00);
    run_op(16'h8016, 8'h00);
    run_op(16'h8017, 8'h00);
    run_op(16'h801F, 8'h00);
    // Skips ignore the low nibble of 5xy0; register Vy is picked by index.
    run_op(16'h5107, 8'h00);
    run_op(16'hC1F0, 8'hAA);
    run_op(16'hE1A1, 8'h00);
    run_op(16'hE155, 8'h00);
    run_op(16'hD123, 8'h00);
    run_op(16'h00E0, 8'h00);
    run_op(16'h0123, 8'h00);
    run_op(16'hF10A, 8'h00);
    run_op(16'hF199, 8'h00);
    run_op(16'h71FF, 8'h00);
    run_op(16'hF115, 8'h00);
    run_op(16'hF118, 8'h00);
    run_op(16'hF207, 8'h00);
    // BCD and block moves wrap at the top of memory.
    run_op(16'hAFFE, 8'h00);
    run_op(16'h62FF, 8'h00);
    run_op(16'hF233, 8'h00);
    run_op(16'hFF55, 8'h00);
    run_op(16'hFF65, 8'h00);
    run_op(16'hF01E, 8'h00);
    run_op(16'h2ABC, 8'h00);
    run_op(16'h00EE, 8'h00);
    run_op(16'hBFFF, 8'h00);
    run_op(16'h1FFE, 8'h00);
    run_op(16'h3000, 8'h00);
    run_op(16'h4000, 8'h00);
    run_op(16'h9120, 8'h00);
  endtask

  task automatic test_config_extremes();
    settle();
    cfg_write(RegProgStart, 32'h0000_0FFF);
    cfg_write(RegStackStart, 32'h0000_00FE);
    run_op(16'h2100, 8'h00);
    run_op(16'h00EE, 8'h00);
    settle();
    cfg_write(RegProgStart, 32'h0000_0000);
    cfg_write(RegStackStart, 32'h0000_0000);
    run_op(16'h00EE, 8'h00);
    repeat (10) random_item();
  endtask

  task automatic test_random_programs();
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      cfg_write(RegProgStart, $urandom_range(0, 4095));
      cfg_write(RegStackStart, $urandom_range(0, 254));
      for (int n = 0; n < 130; n++) begin
        if (phase == 1 && n == 20) hold_left = 400;
        random_item();
      end
    end
  endtask

  task automatic test_no_idling();
    idle_on = 1'b0;
    for (int n = 0; n < 80; n++) random_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0;
    address_i = '0;
    data_i = '0;
    random_byte_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    hold_left = 0;
    stall_left = 0;
    for (int i = 0; i < 4096; i++) mem_known[i] = 1'b0;
    for (int i = 0; i < 16; i++) vregs[i] = '0;
    prog_start = '0;
    stack_base = 8'd200;
    cpu_pc = prog_start;
    cpu_sp = stack_base;
    cpu_idx = '0;
    cpu_dt = '0;
    cpu_st = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_memory_extremes();
    test_opcodes();
    test_config_extremes();
    test_random_programs();
    test_no_idling();
    settle();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/c8ie_pkg.sv
sv/c8ie_mem.sv
sv/chip8_instruction_executor.sv
verif/tb_top.sv
